/* hdl/cpt_pkg.sv */
// Shared types, sizes and codes for the CP tensor reconstruction block.
// No dependencies; every other file in hdl/ imports this package.
package cpt_pkg;

   localparam int MAX_DIM  = 16;
   localparam int MAX_RANK = 16;

   localparam int DIM_W    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int RANK_W   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
   localparam int ADDR_W   = DIM_W + RANK_W;
   localparam int DEPTH    = MAX_DIM * MAX_RANK;

   localparam int REG_W    = 5;
   localparam int POS_W    = 4;
   localparam int VAL_W    = 16;
   localparam int WORD_W   = 2 * VAL_W;
   localparam int ELEM_W   = 24;
   localparam int STAT_W   = 2;
   localparam int CSR_IDX_W = 2;

   // Product widths through the term pipeline
   localparam int P1_W     = 2 * VAL_W;       // a*b partial products
   localparam int P2_W     = P1_W + 1;        // a*b complex product
   localparam int P3_W     = P2_W + VAL_W;    // times c
   localparam int ACC_W    = P3_W + 1 + 4;    // term sum over up to 16 ranks
   localparam int FRAC_DROP = 30;             // Q.45 down to Q.15

   typedef enum logic [1:0] {
      FUNC_LOAD_A  = 2'd0,
      FUNC_LOAD_B  = 2'd1,
      FUNC_LOAD_C  = 2'd2,
      FUNC_COMPUTE = 2'd3
   } func_type;

   typedef enum logic [STAT_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_SAT   = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SIZE_I    = 2'd0,
      CSR_SIZE_J    = 2'd1,
      CSR_SIZE_K    = 2'd2,
      CSR_RANK_USED = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Per-beat control that travels with a term through the pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } term_ctl_type;

   // Register value capped to its maximum
   function automatic logic [REG_W-1:0] eff_limit(input logic [REG_W-1:0] val,
                                                  input logic [REG_W-1:0] cap);
      eff_limit = (val > cap) ? cap : val;
   endfunction

endpackage

/* hdl/cpt_factor_ram.sv */
// One factor store: single write port, single registered read port.
// Depends on cpt_pkg for depth and word width.
module cpt_factor_ram (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [cpt_pkg::ADDR_W-1:0] wr_addr,
   input  logic [cpt_pkg::WORD_W-1:0] wr_data,
   input  logic                       rd_en,
   input  logic [cpt_pkg::ADDR_W-1:0] rd_addr,
   output logic [cpt_pkg::WORD_W-1:0] rd_data
);
   import cpt_pkg::*;

   logic [WORD_W-1:0] mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/cpt_term_pipe.sv */
// Complex triple-product pipeline and rank accumulator, with the final
// round-half-up and 24-bit saturation. Depends on cpt_pkg.
module cpt_term_pipe (
   input  logic                       clock,
   input  logic                       reset,
   input  cpt_pkg::term_ctl_type      ctl,
   input  logic [cpt_pkg::WORD_W-1:0] word_a,
   input  logic [cpt_pkg::WORD_W-1:0] word_b,
   input  logic [cpt_pkg::WORD_W-1:0] word_c,
   output logic                       done,
   output logic [cpt_pkg::ELEM_W-1:0] elem_re,
   output logic [cpt_pkg::ELEM_W-1:0] elem_im,
   output logic                       sat
);
   import cpt_pkg::*;

   logic signed [VAL_W-1:0] ar, ai, br, bi, cr, ci;

   term_ctl_type ctl1_ff, ctl2_ff, ctl3_ff;
   logic [WORD_W-1:0] c1_ff, c2_ff;
   logic signed [P1_W-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [P2_W-1:0] pr_ff, pm_ff;
   logic signed [P3_W-1:0] q_rr_ff, q_mi_ff, q_ri_ff, q_mr_ff;
   logic signed [ACC_W-1:0] acc_re_ff, acc_im_ff, acc_re_in, acc_im_in;
   logic done_ff;

   assign ar = word_a[WORD_W-1:VAL_W];
   assign ai = word_a[VAL_W-1:0];
   assign br = word_b[WORD_W-1:VAL_W];
   assign bi = word_b[VAL_W-1:0];
   assign cr = c2_ff[WORD_W-1:VAL_W];
   assign ci = c2_ff[VAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl1_ff <= ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         done_ff <= ctl3_ff.valid & ctl3_ff.last;
      end
   end

   // stage 1: a*b partial products
   always_ff @(posedge clock) begin
      p_rr_ff <= ar * br;
      p_ii_ff <= ai * bi;
      p_ri_ff <= ar * bi;
      p_ir_ff <= ai * br;
      c1_ff   <= word_c;
   end

   // stage 2: complex a*b
   always_ff @(posedge clock) begin
      pr_ff <= P2_W'(p_rr_ff) - P2_W'(p_ii_ff);
      pm_ff <= P2_W'(p_ri_ff) + P2_W'(p_ir_ff);
      c2_ff <= c1_ff;
   end

   // stage 3: times c
   always_ff @(posedge clock) begin
      q_rr_ff <= pr_ff * P3_W'(cr);
      q_mi_ff <= pm_ff * P3_W'(ci);
      q_ri_ff <= pr_ff * P3_W'(ci);
      q_mr_ff <= pm_ff * P3_W'(cr);
   end

   // stage 4: accumulate over rank, restart on the first term
   always_comb begin
      acc_re_in = (ctl3_ff.first ? '0 : acc_re_ff)
                  + ACC_W'(q_rr_ff) - ACC_W'(q_mi_ff);
      acc_im_in = (ctl3_ff.first ? '0 : acc_im_ff)
                  + ACC_W'(q_ri_ff) + ACC_W'(q_mr_ff);
   end

   always_ff @(posedge clock) begin
      if (ctl3_ff.valid) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

   // Round half up to Q.15 and saturate
   localparam int RND_W = ACC_W + 1;
   localparam int RES_W = RND_W - FRAC_DROP;

   logic signed [RND_W-1:0] rnd_re, rnd_im;
   logic signed [RES_W-1:0] res_re, res_im;
   logic                    ovf_re, ovf_im;

   always_comb begin
      rnd_re = RND_W'(acc_re_ff) + RND_W'(1 << (FRAC_DROP - 1));
      rnd_im = RND_W'(acc_im_ff) + RND_W'(1 << (FRAC_DROP - 1));
      res_re = rnd_re[RND_W-1:FRAC_DROP];
      res_im = rnd_im[RND_W-1:FRAC_DROP];
      // fits in ELEM_W iff all bits above the field copy its sign
      ovf_re = (res_re[RES_W-1:ELEM_W-1] != {(RES_W-ELEM_W+1){res_re[RES_W-1]}});
      ovf_im = (res_im[RES_W-1:ELEM_W-1] != {(RES_W-ELEM_W+1){res_im[RES_W-1]}});
      elem_re = ovf_re ? {res_re[RES_W-1], {(ELEM_W-1){~res_re[RES_W-1]}}}
                       : res_re[ELEM_W-1:0];
      elem_im = ovf_im ? {res_im[RES_W-1], {(ELEM_W-1){~res_im[RES_W-1]}}}
                       : res_im[ELEM_W-1:0];
      sat = ovf_re | ovf_im;
   end

   assign done = done_ff;

endmodule

/* hdl/cp_tensor_reconstruct.sv */
// CP tensor reconstruction: three complex Q1.15 factor stores and the
// sequencer that sums A[i,r]*B[j,r]*C[k,r] over the rank. Uses cpt_pkg,
// cpt_factor_ram and cpt_term_pipe.
//
// Input beats on req_*: tuser carries the function (load A, B, C or compute).
// A load in range writes one factor entry; no load gives a response. Loads are
// taken one per cycle while the block is idle. A compute beat gives exactly one
// response beat on rsp_*, with the element in tdata and the status in tuser.
// A compute in range reads one rank column per cycle from the three stores
// (one read port each) into the term pipeline; its response is registered
// once the pipeline signals done and the response slot is free; the next beat
// is taken in the cycle after that. An out-of-range compute or a rank of zero
// skips the stores and registers its response as soon as the slot is free.
// The next beat is accepted even while the response waits on rsp_tready.
// Sizes and rank are set through the csr_* write port (always ready) and
// must only change while the block is idle.
// Reset clears control and the size registers to 16; factor stores are not
// cleared and must be loaded before use. A stalled rsp side holds the
// response and, for a following compute, the final write into the response
// register until the slot is free.
module cp_tensor_reconstruct (
   input  logic                          clock,
   input  logic                          reset,
   // input stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: pos_i[3:0], pos_j[7:4], pos_k[11:8], rank_pos[15:12],
   //        value_re[31:16], value_im[47:32]
   input  logic [47:0]                   req_tdata,
   // tuser: func[1:0]
   input  logic [1:0]                    req_tuser,
   // result stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata: elem_re[23:0], elem_im[47:24]
   output logic [47:0]                   rsp_tdata,
   // tuser: status[1:0]
   output logic [cpt_pkg::STAT_W-1:0]    rsp_tuser,
   // register writes
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cpt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [cpt_pkg::REG_W-1:0]     csr_wdata
);
   import cpt_pkg::*;

   localparam logic [REG_W-1:0] DIM_CAP  = REG_W'(MAX_DIM);
   localparam logic [REG_W-1:0] RANK_CAP = REG_W'(MAX_RANK);
   localparam logic [REG_W-1:0] REG_RST  = REG_W'(16);

   // ---- configuration ----
   logic [REG_W-1:0] size_i_ff, size_j_ff, size_k_ff, rank_used_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_i_ff    <= REG_RST;
         size_j_ff    <= REG_RST;
         size_k_ff    <= REG_RST;
         rank_used_ff <= REG_RST;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIZE_I:    size_i_ff    <= csr_wdata;
            CSR_SIZE_J:    size_j_ff    <= csr_wdata;
            CSR_SIZE_K:    size_k_ff    <= csr_wdata;
            CSR_RANK_USED: rank_used_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [REG_W-1:0] lim_i, lim_j, lim_k, lim_r;
   assign lim_i = eff_limit(size_i_ff, DIM_CAP);
   assign lim_j = eff_limit(size_j_ff, DIM_CAP);
   assign lim_k = eff_limit(size_k_ff, DIM_CAP);
   assign lim_r = eff_limit(rank_used_ff, RANK_CAP);

   // ---- input fields ----
   func_type          func;
   logic [POS_W-1:0]  pos_i, pos_j, pos_k, rank_pos;
   logic [WORD_W-1:0] word_in;

   assign func     = func_type'(req_tuser);
   assign pos_i    = req_tdata[3:0];
   assign pos_j    = req_tdata[7:4];
   assign pos_k    = req_tdata[11:8];
   assign rank_pos = req_tdata[15:12];
   assign word_in  = {req_tdata[31:16], req_tdata[47:32]};

   // ---- sequencer ----
   state_type         state_ff, state_in;
   logic [POS_W-1:0]  ci_ff, cj_ff, ck_ff, ci_in, cj_in, ck_in;
   logic [REG_W-1:0]  er_ff, er_in, rcnt_ff, rcnt_in;
   logic              err_ff, err_in, empty_ff, empty_in;
   term_ctl_type      issue, ctl_ff;
   logic              wr_a, wr_b, wr_c, rd_en;
   logic [ADDR_W-1:0] wr_addr;
   logic              rsp_load;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [ELEM_W-1:0] rsp_re_ff, rsp_im_ff;
   status_type        rsp_status_ff;

   logic              done, sat;
   logic [ELEM_W-1:0] elem_re, elem_im;

   logic              load_ok;
   logic [POS_W-1:0]  load_row;
   logic [REG_W-1:0]  load_lim;

   always_comb begin
      unique case (func)
         FUNC_LOAD_A: begin
            load_row = pos_i;
            load_lim = lim_i;
         end
         FUNC_LOAD_B: begin
            load_row = pos_j;
            load_lim = lim_j;
         end
         default: begin
            load_row = pos_k;
            load_lim = lim_k;
         end
      endcase
      load_ok = (REG_W'(load_row) < load_lim) && (REG_W'(rank_pos) < lim_r);
   end

   assign wr_addr = {load_row[DIM_W-1:0], rank_pos[RANK_W-1:0]};

   always_comb begin
      state_in   = state_ff;
      ci_in      = ci_ff;
      cj_in      = cj_ff;
      ck_in      = ck_ff;
      er_in      = er_ff;
      rcnt_in    = rcnt_ff;
      err_in     = err_ff;
      empty_in   = empty_ff;
      req_tready = 1'b0;
      wr_a       = 1'b0;
      wr_b       = 1'b0;
      wr_c       = 1'b0;
      rd_en      = 1'b0;
      issue      = '0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (func == FUNC_COMPUTE) begin
                  ci_in    = pos_i;
                  cj_in    = pos_j;
                  ck_in    = pos_k;
                  er_in    = lim_r;
                  rcnt_in  = '0;
                  err_in   = (REG_W'(pos_i) >= lim_i) || (REG_W'(pos_j) >= lim_j)
                             || (REG_W'(pos_k) >= lim_k);
                  empty_in = (lim_r == '0);
                  state_in = (err_in || empty_in) ? ST_FINISH : ST_ISSUE;
               end else begin
                  wr_a = load_ok && (func == FUNC_LOAD_A);
                  wr_b = load_ok && (func == FUNC_LOAD_B);
                  wr_c = load_ok && (func == FUNC_LOAD_C);
               end
            end
         end
         ST_ISSUE: begin
            rd_en       = 1'b1;
            issue.valid = 1'b1;
            issue.first = (rcnt_ff == '0);
            issue.last  = (rcnt_ff == er_ff - REG_W'(1));
            rcnt_in     = rcnt_ff + REG_W'(1);
            if (issue.last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ctl_ff   <= issue;
      end
   end

   always_ff @(posedge clock) begin
      ci_ff    <= ci_in;
      cj_ff    <= cj_in;
      ck_ff    <= ck_in;
      er_ff    <= er_in;
      rcnt_ff  <= rcnt_in;
      err_ff   <= err_in;
      empty_ff <= empty_in;
   end

   // ---- factor stores ----
   logic [RANK_W-1:0] rd_rank;
   logic [WORD_W-1:0] word_a, word_b, word_c;

   assign rd_rank = rcnt_ff[RANK_W-1:0];

   cpt_factor_ram u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (word_in),
      .rd_en   (rd_en),
      .rd_addr ({ci_ff[DIM_W-1:0], rd_rank}),
      .rd_data (word_a)
   );

   cpt_factor_ram u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (word_in),
      .rd_en   (rd_en),
      .rd_addr ({cj_ff[DIM_W-1:0], rd_rank}),
      .rd_data (word_b)
   );

   cpt_factor_ram u_ram_c (
      .clock   (clock),
      .wr_en   (wr_c),
      .wr_addr (wr_addr),
      .wr_data (word_in),
      .rd_en   (rd_en),
      .rd_addr ({ck_ff[DIM_W-1:0], rd_rank}),
      .rd_data (word_c)
   );

   // ---- term pipeline ----
   cpt_term_pipe u_pipe (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_ff),
      .word_a  (word_a),
      .word_b  (word_b),
      .word_c  (word_c),
      .done    (done),
      .elem_re (elem_re),
      .elem_im (elem_im),
      .sat     (sat)
   );

   // ---- response register ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         priority if (err_ff) begin
            rsp_re_ff     <= '0;
            rsp_im_ff     <= '0;
            rsp_status_ff <= STATUS_RANGE;
         end else if (empty_ff) begin
            rsp_re_ff     <= '0;
            rsp_im_ff     <= '0;
            rsp_status_ff <= STATUS_OK;
         end else begin
            rsp_re_ff     <= elem_re;
            rsp_im_ff     <= elem_im;
            rsp_status_ff <= sat ? STATUS_SAT : STATUS_OK;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_im_ff, rsp_re_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

/* tb/tb_top.sv */
// Self-checking bench for cp_tensor_reconstruct: loads complex Q1.15 factors,
// asks for tensor elements and checks each against a predictor kept in the bench.
// Depends on cpt_pkg and the RTL under hdl/; reads no files.
module tb_top;
   import cpt_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = MAX_RANK + 16;
   localparam int LONG_HOLD     = 400;

   typedef struct {
      func_type    func;
      logic [3:0]  pos_i, pos_j, pos_k, rank_pos;
      logic [15:0] val_re, val_im;
   } factor_beat_type;

   typedef struct {
      logic signed [23:0] re, im;
      status_type         status;
   } element_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [STAT_W-1:0]    rsp_tuser;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]     csr_wdata = '0;

   cp_tensor_reconstruct uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   // stimulus side
   factor_beat_type factor_beat_q[$];
   int           sent_total = 0;
   logic [4:0]   plan_regs [4] = '{5'd16, 5'd16, 5'd16, 5'd16};
   bit           plan_set [3][DEPTH];
   bit           calm = 1'b0;
   int           hold_asked = 0;
   int           cfg_settings = 0;

   // checking side
   element_type  element_expect_q[$];
   logic [31:0]  factor_mirror [3][DEPTH];
   logic [4:0]   reg_mirror [4] = '{5'd16, 5'd16, 5'd16, 5'd16};
   int           taken_total = 0;
   int           fail_count = 0;
   int           n_elements = 0;
   int           n_range = 0;
   int           n_sat = 0;
   int           n_loads = 0;

   logic         req_taken = 1'b0;
   int           send_gap = 0;
   int           hold_served = 0;
   int           hold_left = 0;
   int           stall_left = 0;
   int           cycle_count = 0;

   function automatic int cap_reg(logic [4:0] v, int cap);
      return (int'(v) > cap) ? cap : int'(v);
   endfunction

   function automatic longint q15_part(logic [15:0] h);
      return longint'($signed(h));
   endfunction

   function automatic logic [15:0] rand_q15();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Sum over the rank of A[i,r]*B[j,r]*C[k,r], exact in Q.45, then Q9.15
   function automatic element_type reconstruct_element(logic [3:0] pi, logic [3:0] pj,
                                                       logic [3:0] pk);
      element_type e;
      longint   acc_re, acc_im, ar, ai, br, bi, cr, ci, pr, pm, rre, rim;
      logic [31:0] wa, wb, wc;
      int       ei, ej, ek, er;
      bit       hit;
      ei = cap_reg(reg_mirror[0], MAX_DIM);
      ej = cap_reg(reg_mirror[1], MAX_DIM);
      ek = cap_reg(reg_mirror[2], MAX_DIM);
      er = cap_reg(reg_mirror[3], MAX_RANK);
      e.re = '0;
      e.im = '0;
      e.status = STATUS_OK;
      if (pi >= ei || pj >= ej || pk >= ek) begin
         e.status = STATUS_RANGE;
         return e;
      end
      acc_re = 0;
      acc_im = 0;
      for (int r = 0; r < er; r++) begin
         wa = factor_mirror[0][pi*MAX_RANK + r];
         wb = factor_mirror[1][pj*MAX_RANK + r];
         wc = factor_mirror[2][pk*MAX_RANK + r];
         ar = q15_part(wa[31:16]); ai = q15_part(wa[15:0]);
         br = q15_part(wb[31:16]); bi = q15_part(wb[15:0]);
         cr = q15_part(wc[31:16]); ci = q15_part(wc[15:0]);
         pr = ar*br - ai*bi;
         pm = ar*bi + ai*br;
         acc_re += pr*cr - pm*ci;
         acc_im += pr*ci + pm*cr;
      end
      // round half up: add half an LSB, then floor
      rre = (acc_re + 64'sd536870912) >>> 30;
      rim = (acc_im + 64'sd536870912) >>> 30;
      hit = 1'b0;
      if (rre > 8388607) begin rre = 8388607; hit = 1'b1; end
      if (rre < -8388608) begin rre = -8388608; hit = 1'b1; end
      if (rim > 8388607) begin rim = 8388607; hit = 1'b1; end
      if (rim < -8388608) begin rim = -8388608; hit = 1'b1; end
      e.re = rre[23:0];
      e.im = rim[23:0];
      if (hit)
         e.status = STATUS_SAT;
      return e;
   endfunction

   // request driver: a new beat only once the current one has gone
   always @(negedge clock) begin : drive_req
      factor_beat_type b;
      if (!reset && (!req_tvalid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (factor_beat_q.size() > 0) begin
            b = factor_beat_q.pop_front();
            req_tdata <= {b.val_im, b.val_re, b.rank_pos, b.pos_k, b.pos_j, b.pos_i};
            req_tuser <= b.func;
            req_tvalid <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0)
               send_gap <= $urandom_range(1, 12);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side back-pressure
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_served != hold_asked) begin
         hold_served <= hold_served + 1;
         hold_left <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         stall_left <= $urandom_range(1, 12) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: register mirror, factor mirror and element checks
   always @(posedge clock) begin : watch
      func_type    fn;
      logic [3:0]  pi, pj, pk, rp, row;
      int          lim, er;
      element_type e;
      req_taken <= req_tvalid && req_tready;
      if (!reset) begin
         if (csr_valid && csr_ready)
            reg_mirror[csr_index] = csr_wdata;
         if (req_tvalid && req_tready) begin
            taken_total++;
            fn = func_type'(req_tuser);
            pi = req_tdata[3:0];
            pj = req_tdata[7:4];
            pk = req_tdata[11:8];
            rp = req_tdata[15:12];
            if (fn == FUNC_COMPUTE) begin
               element_expect_q.push_back(reconstruct_element(pi, pj, pk));
            end else begin
               n_loads++;
               row = (fn == FUNC_LOAD_A) ? pi : (fn == FUNC_LOAD_B) ? pj : pk;
               lim = cap_reg(reg_mirror[int'(fn)], MAX_DIM);
               er = cap_reg(reg_mirror[3], MAX_RANK);
               // stored word: real part high, imaginary part low
               if (row < lim && rp < er)
                  factor_mirror[int'(fn)][row*MAX_RANK + rp] =
                     {req_tdata[31:16], req_tdata[47:32]};
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (element_expect_q.size() == 0) begin
               $error("unexpected result beat: re %0d im %0d status %0d",
                      $signed(rsp_tdata[23:0]), $signed(rsp_tdata[47:24]), rsp_tuser);
               fail_count++;
            end else begin
               e = element_expect_q.pop_front();
               n_elements++;
               if (e.status == STATUS_RANGE) n_range++;
               if (e.status == STATUS_SAT) n_sat++;
               if (rsp_tdata[23:0] !== e.re) begin
                  $error("elem_re: expected %0d, got %0d", e.re, $signed(rsp_tdata[23:0]));
                  fail_count++;
               end
               if (rsp_tdata[47:24] !== e.im) begin
                  $error("elem_im: expected %0d, got %0d", e.im, $signed(rsp_tdata[47:24]));
                  fail_count++;
               end
               if (rsp_tuser !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_csr(csr_index_type idx, logic [4:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_config(logic [4:0] si, logic [4:0] sj, logic [4:0] sk,
                             logic [4:0] rk);
      write_csr(CSR_SIZE_I, si);
      write_csr(CSR_SIZE_J, sj);
      write_csr(CSR_SIZE_K, sk);
      write_csr(CSR_RANK_USED, rk);
      plan_regs[0] = si;
      plan_regs[1] = sj;
      plan_regs[2] = sk;
      plan_regs[3] = rk;
      cfg_settings++;
   endtask

   task automatic wait_results();
      while (!(taken_total == sent_total && element_expect_q.size() == 0))
         @(posedge clock);
   endtask

   // everything back, then room for a load still in the pipe
   task automatic drain();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic push_beat(func_type fn, int pi, int pj, int pk, int rp,
                            logic [15:0] vre, logic [15:0] vim);
      factor_beat_type b;
      int row, lim, er;
      b.func = fn;
      b.pos_i = pi[3:0];
      b.pos_j = pj[3:0];
      b.pos_k = pk[3:0];
      b.rank_pos = rp[3:0];
      b.val_re = vre;
      b.val_im = vim;
      factor_beat_q.push_back(b);
      sent_total++;
      if (fn != FUNC_COMPUTE) begin
         row = (fn == FUNC_LOAD_A) ? pi : (fn == FUNC_LOAD_B) ? pj : pk;
         lim = cap_reg(plan_regs[int'(fn)], MAX_DIM);
         er = cap_reg(plan_regs[3], MAX_RANK);
         if (row < lim && rp < er)
            plan_set[int'(fn)][row*MAX_RANK + rp] = 1'b1;
      end
   endtask

   task automatic push_load(int f, int row, int col, logic [15:0] vre, logic [15:0] vim);
      int pos[3];
      pos[0] = $urandom_range(0, 15);
      pos[1] = $urandom_range(0, 15);
      pos[2] = $urandom_range(0, 15);
      pos[f] = row;
      push_beat(func_type'(f), pos[0], pos[1], pos[2], col, vre, vim);
   endtask

   function automatic bit find_missing(int i, int j, int k, int er,
                                       output int f, output int row, output int col);
      int rows[3];
      rows[0] = i;
      rows[1] = j;
      rows[2] = k;
      f = 0;
      row = 0;
      col = 0;
      for (int ff = 0; ff < 3; ff++)
         for (int c = 0; c < er; c++)
            if (!plan_set[ff][rows[ff]*MAX_RANK + c]) begin
               f = ff;
               row = rows[ff];
               col = c;
               return 1'b1;
            end
      return 1'b0;
   endfunction

   // mostly the first few rows, so rows fill up and computes get through
   function automatic int pick_row(int lim);
      if ($urandom_range(0, 3) != 0)
         return $urandom_range(0, (lim < 4 ? lim : 4) - 1);
      return $urandom_range(0, lim - 1);
   endfunction

   function automatic logic [4:0] rand_size();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) return 5'd0;
      if (p < 18) return 5'($urandom_range(17, 31));
      if (p < 30) return 5'd16;
      return 5'($urandom_range(1, 4));
   endfunction

   function automatic logic [4:0] rand_rank();
      int p;
      p = $urandom_range(0, 99);
      if (p < 8) return 5'd0;
      if (p < 16) return 5'($urandom_range(17, 31));
      if (p < 30) return 5'd16;
      return 5'($urandom_range(1, 8));
   endfunction

   task automatic random_phase(int n, bit pause_mid);
      int useful, pick, ei, ej, ek, er, i, j, k, f, row, col, lim;
      bit paused;
      func_type fn;
      ei = cap_reg(plan_regs[0], MAX_DIM);
      ej = cap_reg(plan_regs[1], MAX_DIM);
      ek = cap_reg(plan_regs[2], MAX_DIM);
      er = cap_reg(plan_regs[3], MAX_RANK);
      useful = 0;
      paused = 1'b0;
      while (useful < n) begin
         if (pause_mid && !paused && useful >= n/2) begin
            wait_results();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            useful++;
            if (ei == 0 || ej == 0 || ek == 0) begin
               push_beat(FUNC_COMPUTE, $urandom_range(0, 15), $urandom_range(0, 15),
                         $urandom_range(0, 15), $urandom_range(0, 15),
                         16'($urandom), 16'($urandom));
            end else begin
               i = pick_row(ei);
               j = pick_row(ej);
               k = pick_row(ek);
               if (find_missing(i, j, k, er, f, row, col))
                  push_load(f, row, col, rand_q15(), rand_q15());
               else
                  push_beat(FUNC_COMPUTE, i, j, k, $urandom_range(0, 15),
                            16'($urandom), 16'($urandom));
            end
         end else if (pick < 88) begin
            f = $urandom_range(0, 2);
            lim = cap_reg(plan_regs[f], MAX_DIM);
            if (lim > 0 && er > 0) begin
               useful++;
               push_load(f, pick_row(lim), $urandom_range(0, er - 1), rand_q15(), rand_q15());
            end else begin
               push_load(f, $urandom_range(0, 15), $urandom_range(0, 15), rand_q15(),
                         rand_q15());
            end
         end else begin
            // noise: any field any value, but never a read of an unwritten entry
            fn = func_type'($urandom_range(0, 3));
            i = $urandom_range(0, 15);
            j = $urandom_range(0, 15);
            k = $urandom_range(0, 15);
            if (fn == FUNC_COMPUTE && i < ei && j < ej && k < ek &&
                find_missing(i, j, k, er, f, row, col))
               fn = FUNC_LOAD_A;
            push_beat(fn, i, j, k, $urandom_range(0, 15), 16'($urandom), 16'($urandom));
         end
      end
      drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extreme values on rank column 0, one term per element
      set_config(5'd16, 5'd16, 5'd16, 5'd1);
      push_load(FUNC_LOAD_A, 0, 0, 16'h7fff, 16'h8000);
      push_load(FUNC_LOAD_B, 0, 0, 16'h8000, 16'h7fff);
      push_load(FUNC_LOAD_C, 0, 0, 16'h8000, 16'h8000);
      push_beat(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0000, 16'h0000);
      push_load(FUNC_LOAD_A, 15, 0, 16'h8000, 16'h0000);
      push_load(FUNC_LOAD_B, 15, 0, 16'h7fff, 16'h7fff);
      push_load(FUNC_LOAD_C, 15, 0, 16'hffff, 16'h0001);
      push_beat(FUNC_COMPUTE, 15, 15, 15, 15, 16'hffff, 16'hffff);
      push_beat(FUNC_COMPUTE, 0, 15, 0, 0, 16'h5555, 16'haaaa);
      // rank column past the rank in use: dropped
      push_load(FUNC_LOAD_A, 0, 15, 16'h5555, 16'haaaa);
      push_beat(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0000, 16'h0000);
      drain();

      // empty sum, compute and load past size_i
      set_config(5'd1, 5'd16, 5'd16, 5'd0);
      push_beat(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0000, 16'h0000);
      push_beat(FUNC_COMPUTE, 1, 0, 0, 0, 16'h0000, 16'h0000);
      push_load(FUNC_LOAD_A, 1, 0, 16'h1234, 16'h4321);
      push_beat(FUNC_COMPUTE, 15, 15, 15, 0, 16'h0000, 16'h0000);
      drain();

      // zero size, rank above its maximum
      set_config(5'd16, 5'd16, 5'd0, 5'd31);
      push_beat(FUNC_COMPUTE, 0, 0, 0, 0, 16'h0000, 16'h0000);
      push_load(FUNC_LOAD_C, 0, 0, 16'h7fff, 16'h7fff);
      drain();

      // fill the first rows over the full rank
      set_config(5'd31, 5'd31, 5'd31, 5'd16);
      for (int row = 0; row < 4; row++)
         for (int col = 0; col < MAX_RANK; col++)
            for (int f = 0; f < 3; f++)
               push_load(f, row, col, rand_q15(), rand_q15());
      drain();

      set_config(5'd16, 5'd16, 5'd16, 5'd16);
      hold_asked++;
      random_phase(30, 1'b0);

      set_config(5'd1, 5'd1, 5'd1, 5'd1);
      random_phase(20, 1'b1);

      for (int p = 0; p < 5; p++) begin
         set_config(rand_size(), rand_size(), rand_size(), rand_rank());
         random_phase(20, p == 2);
      end

      calm = 1'b1;
      set_config(5'd4, 5'd3, 5'd2, 5'd16);
      random_phase(20, 1'b0);

      $display("Checked %0d elements (%0d out of range, %0d saturated), %0d loads",
               n_elements, n_range, n_sat, n_loads);
      $display("Beats sent %0d across %0d register settings", sent_total, cfg_settings);
      if (fail_count == 0 && element_expect_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

/* filelist.f */
hdl/cpt_pkg.sv
hdl/cpt_factor_ram.sv
hdl/cpt_term_pipe.sv
hdl/cp_tensor_reconstruct.sv
tb/tb_top.sv
